FILE: design/tcw_pkg.sv
// Shared constants, types and the address helper function of the text console writer.
package tcw_pkg;

    // Screen geometry and tab spacing.
    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 4;
    localparam int CELLS    = COLUMNS * ROWS;

    // Fixed field widths of the channels.
    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int IDX_W      = 11;
    localparam int CELL_W     = 16;
    localparam int OUT_COL_W  = 7;
    localparam int OUT_ROW_W  = 5;
    localparam int ATTR_W     = 8;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Internal widths derived from the geometry.
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int CNT_W    = $clog2(CELLS + 1);
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int ROW_W    = $clog2(ROWS);
    localparam int PH_W     = $clog2(TAB_STOP);
    localparam int SUM_W    = $clog2(COLUMNS + TAB_STOP + 1);
    localparam int SUM_A_W  = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 1;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Character codes with special handling.
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // Attribute after reset.
    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

    // Register index (byte address bit 2 selects the register).
    localparam logic REG_ATTR = 1'b0;

    // Write request to the screen store.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] data;
    } t_mem_wr;

    // Read request to the screen store.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_mem_rd;

    // Fold a sum below twice the store size back into the store.
    function automatic logic [ADDR_W-1:0] wrap_addr(input logic [SUM_A_W-1:0] s);
        logic [SUM_A_W-1:0] d;
        d = s - SUM_A_W'(CELLS);
        if (s >= SUM_A_W'(CELLS)) begin
            return d[ADDR_W-1:0];
        end
        return s[ADDR_W-1:0];
    endfunction

endpackage

FILE: design/tcw_if.sv
// Handshake channel interfaces for command items and result items.
interface tcw_cmd_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;

    modport source (output valid, command, char_code, cell_index, input ready);
    modport sink   (input valid, command, char_code, cell_index, output ready);
endinterface

interface tcw_res_if import tcw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CELL_W-1:0]    cell_value;
    logic [OUT_COL_W-1:0] cursor_col;
    logic [OUT_ROW_W-1:0] cursor_row;
    logic                 scrolled;

    modport source (output valid, cell_value, cursor_col, cursor_row, scrolled, input ready);
    modport sink   (input valid, cell_value, cursor_col, cursor_row, scrolled, output ready);
endinterface

FILE: design/tcw_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module tcw_ram #(
    parameter int DEPTH = 2000,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/tcw_apb.sv
// APB-style configuration register block holding the text attribute.
module tcw_apb import tcw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [ATTR_W-1:0]     o_attr
);

    logic [ATTR_W-1:0] r_attr;
    logic              wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_ATTR);

    // Attribute register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= RESET_ATTR;
        end else if (wr_hit) begin
            r_attr <= pwdata[ATTR_W-1:0];
        end
    end

    // Read-back decoder.
    always_comb begin
        unique case (paddr[2])
            REG_ATTR: prdata = APB_DATA_W'(r_attr);
            default:  prdata = '0;
        endcase
    end

    assign o_attr = r_attr;

endmodule

FILE: design/tcw_ctrl.sv
// Console sequencer: cursor, row offset, store sweeps and the result register.
module tcw_ctrl import tcw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [ATTR_W-1:0] i_attr,
    tcw_cmd_if.sink           i_cmd,
    tcw_res_if.source         o_res,
    output t_mem_wr           o_mem_wr,
    output t_mem_rd           o_mem_rd,
    input  logic [CELL_W-1:0] i_mem_rd_data
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_FILL,
        S_DONE
    } t_state;

    t_state               r_state, n_state;
    logic [CMD_W-1:0]     r_cmd;
    logic [CHAR_W-1:0]    r_char;
    logic [IDX_W-1:0]     r_idx;
    logic [COL_W-1:0]     r_col, n_col;
    logic [ROW_W-1:0]     r_row, n_row;
    logic [PH_W-1:0]      r_phase, n_phase;
    logic [ADDR_W-1:0]    r_base, n_base;
    logic [ADDR_W-1:0]    r_fill_addr, n_fill_addr;
    logic [CNT_W-1:0]     r_fill_left, n_fill_left;
    logic [CELL_W-1:0]    r_fill_data, n_fill_data;
    logic [CELL_W-1:0]    r_cell, n_cell;
    logic                 r_scrolled, n_scrolled;
    logic                 r_out_valid, n_out_valid;
    logic [CELL_W-1:0]    r_out_cell, n_out_cell;
    logic [OUT_COL_W-1:0] r_out_col, n_out_col;
    logic [OUT_ROW_W-1:0] r_out_row, n_out_row;
    logic                 r_out_scr, n_out_scr;

    logic                 accept;
    logic [SUM_W-1:0]     col_inc;
    logic [SUM_W-1:0]     col_tab;
    logic [SUM_A_W-1:0]   cur_sum;
    logic [SUM_A_W-1:0]   idx_sum;
    logic [SUM_A_W-1:0]   base_sum;
    logic [CELL_W-1:0]    blank;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign accept      = i_cmd.valid && (r_state == S_IDLE);

    // Address arithmetic: logical cells are rotated by the row offset.
    assign col_inc  = SUM_W'(r_col) + SUM_W'(1);
    assign col_tab  = SUM_W'(r_col) + SUM_W'(TAB_STOP) - SUM_W'(r_phase);
    assign cur_sum  = SUM_A_W'(r_row) * SUM_A_W'(COLUMNS) + SUM_A_W'(r_col)
                      + SUM_A_W'(r_base);
    assign idx_sum  = SUM_A_W'(r_idx) + SUM_A_W'(r_base);
    assign base_sum = SUM_A_W'(r_base) + SUM_A_W'(COLUMNS);
    assign blank    = {i_attr, CH_SPACE};

    // Next-state logic of the sequencer.
    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_phase     = r_phase;
        n_base      = r_base;
        n_fill_addr = r_fill_addr;
        n_fill_left = r_fill_left;
        n_fill_data = r_fill_data;
        n_cell      = r_cell;
        n_scrolled  = r_scrolled;
        n_out_valid = r_out_valid;
        n_out_cell  = r_out_cell;
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;
        n_out_scr   = r_out_scr;
        o_mem_wr    = '0;
        o_mem_rd    = '0;

        // The result register empties when the receiver takes it.
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_INIT, S_FILL: begin
                o_mem_wr.en   = 1'b1;
                o_mem_wr.addr = r_fill_addr;
                o_mem_wr.data = r_fill_data;
                n_fill_addr   = r_fill_addr + ADDR_W'(1);
                n_fill_left   = r_fill_left - CNT_W'(1);
                if (r_fill_left == CNT_W'(1)) begin
                    n_state = (r_state == S_INIT) ? S_IDLE : S_DONE;
                end
            end

            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_cell     = '0;
                n_scrolled = 1'b0;
                n_state    = S_DONE;
                case (r_cmd)
                    CMD_PUT: begin
                        logic new_line;
                        new_line = 1'b0;
                        if (r_char == CH_LF) begin
                            new_line = 1'b1;
                        end else if (r_char == CH_CR) begin
                            n_col   = '0;
                            n_phase = '0;
                        end else if (r_char == CH_TAB) begin
                            if (col_tab >= SUM_W'(COLUMNS)) begin
                                new_line = 1'b1;
                            end else begin
                                n_col   = col_tab[COL_W-1:0];
                                n_phase = '0;
                            end
                        end else begin
                            o_mem_wr.en   = 1'b1;
                            o_mem_wr.addr = wrap_addr(cur_sum);
                            o_mem_wr.data = {i_attr, r_char};
                            if (col_inc == SUM_W'(COLUMNS)) begin
                                new_line = 1'b1;
                            end else begin
                                n_col   = col_inc[COL_W-1:0];
                                n_phase = (r_phase == PH_W'(TAB_STOP - 1)) ?
                                          '0 : r_phase + PH_W'(1);
                            end
                        end
                        // Move to the next row; past the last row rotate the
                        // store by one row and blank the new bottom row.
                        if (new_line) begin
                            n_col   = '0;
                            n_phase = '0;
                            if (r_row == ROW_W'(ROWS - 1)) begin
                                n_scrolled  = 1'b1;
                                n_base      = wrap_addr(base_sum);
                                n_fill_addr = r_base;
                                n_fill_left = CNT_W'(COLUMNS);
                                n_fill_data = blank;
                                n_state     = S_FILL;
                            end else begin
                                n_row = r_row + ROW_W'(1);
                            end
                        end
                    end
                    CMD_CLEAR: begin
                        n_col       = '0;
                        n_row       = '0;
                        n_phase     = '0;
                        n_base      = '0;
                        n_fill_addr = '0;
                        n_fill_left = CNT_W'(CELLS);
                        n_fill_data = blank;
                        n_state     = S_FILL;
                    end
                    CMD_READ: begin
                        if (SUM_A_W'(r_idx) < SUM_A_W'(CELLS)) begin
                            o_mem_rd.en   = 1'b1;
                            o_mem_rd.addr = wrap_addr(idx_sum);
                            n_state       = S_RDWAIT;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            S_RDWAIT: begin
                n_cell  = i_mem_rd_data;
                n_state = S_DONE;
            end

            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_cell  = r_cell;
                    n_out_col   = OUT_COL_W'(r_col);
                    n_out_row   = OUT_ROW_W'(r_row);
                    n_out_scr   = r_scrolled;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, cursor and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_col       <= '0;
            r_row       <= '0;
            r_phase     <= '0;
            r_base      <= '0;
            r_fill_addr <= '0;
            r_fill_left <= CNT_W'(CELLS);
            r_fill_data <= {RESET_ATTR, CH_SPACE};
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_phase     <= n_phase;
            r_base      <= n_base;
            r_fill_addr <= n_fill_addr;
            r_fill_left <= n_fill_left;
            r_fill_data <= n_fill_data;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_cmd.command;
            r_char <= i_cmd.char_code;
            r_idx  <= i_cmd.cell_index;
        end
        r_cell     <= n_cell;
        r_scrolled <= n_scrolled;
        r_out_cell <= n_out_cell;
        r_out_col  <= n_out_col;
        r_out_row  <= n_out_row;
        r_out_scr  <= n_out_scr;
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.cell_value = r_out_cell;
    assign o_res.cursor_col = r_out_col;
    assign o_res.cursor_row = r_out_row;
    assign o_res.scrolled   = r_out_scr;

endmodule

FILE: design/text_console_writer_core.sv
// Top level of the text console writer: sequencer, screen store and register port.
//
// Command items enter on i_cmd (valid/ready) and each one gives exactly one
// result item on o_res (valid/ready). A put item passes the EXEC and DONE
// states, a read item EXEC, RDWAIT and DONE (the store read data is registered),
// before its result enters the result register; DONE waits while that register
// is full and not taken. The next item is taken back in IDLE. A put that moves
// past the last row first blanks the new bottom row (COLUMNS cells, 80) in the
// FILL state; scrolling itself only moves a row offset. A clear item sweeps the
// whole store (CELLS cells, 2000) in FILL; each sweep writes one cell per cycle.
// After reset the block sweeps all CELLS (2000) cells of the store with blank
// cells in attribute 0x0F and accepts no item in that time; register writes are
// taken throughout. The cursor returns to the top-left cell.
// A finished result waits in an output register; while it is not taken the
// block still accepts and works on the next item, and holds that item's result
// until the register frees up.
// The attribute register sits at byte address 0 of the APB-style port.
module text_console_writer_core import tcw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tcw_cmd_if.sink               i_cmd,
    tcw_res_if.source             o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [ATTR_W-1:0] attr;
    t_mem_wr           mem_wr;
    t_mem_rd           mem_rd;
    logic [CELL_W-1:0] mem_rd_data;

    // Configuration register.
    tcw_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_attr  (attr)
    );

    // Sequencer.
    tcw_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_attr        (attr),
        .i_cmd         (i_cmd),
        .o_res         (o_res),
        .o_mem_wr      (mem_wr),
        .o_mem_rd      (mem_rd),
        .i_mem_rd_data (mem_rd_data)
    );

    // Screen store.
    tcw_ram #(
        .DEPTH (CELLS),
        .WIDTH (CELL_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr.en),
        .i_wr_addr (mem_wr.addr),
        .i_wr_data (mem_wr.data),
        .i_rd_en   (mem_rd.en),
        .i_rd_addr (mem_rd.addr),
        .o_rd_data (mem_rd_data)
    );

endmodule
